### sv/gdai_pkg.sv
// shared types and constants for the gyro dead-band angle integrator
package gdai_pkg;

    localparam int NUM_AXES        = 3;
    localparam int RATE_W          = 16;
    localparam int ABS_W           = 15;
    localparam int SUM_W           = 23;
    localparam int CNT_W           = 8;
    localparam int THR_W           = 15;
    localparam int GAIN_W          = 24;
    localparam int ANGLE_W         = 48;
    localparam int PROD_W          = RATE_W + GAIN_W + 1;
    localparam int RECIP_W         = 32;
    localparam int RECIP_SHIFT     = 31;
    localparam int CAL_SAMPLES_DEF = 200;

    localparam logic [GAIN_W-1:0] GAIN_RESET = 24'd2308974;

    // 360 degrees in Q15.32, and the saturation limits of the angle
    localparam logic signed [ANGLE_W-1:0] DEG360    = 48'sh0168_0000_0000;
    localparam logic signed [ANGLE_W-1:0] ANGLE_MAX = {1'b0, {(ANGLE_W-1){1'b1}}};
    localparam logic signed [ANGLE_W-1:0] ANGLE_MIN = {1'b1, {(ANGLE_W-1){1'b0}}};

    // sample kinds carried in tuser
    localparam logic ACT_CAL = 1'b0;
    localparam logic ACT_INT = 1'b1;

    typedef logic signed [RATE_W-1:0]  t_rate;
    typedef logic        [THR_W-1:0]   t_thr;
    typedef logic        [GAIN_W-1:0]  t_gain;
    typedef logic signed [ANGLE_W-1:0] t_angle;

    // per-word step controls handed to the axis and calibration units
    typedef struct packed {
        logic cal_en;
        logic int_en;
    } t_step_ctl;

endpackage

### sv/gyro_deadband_angle_integrator_top.sv
// top level of the gyro dead-band angle integrator
// Takes one three-axis rate word per clock when not stalled and returns one word per
// input word; the accepted word sits in the input register and moves into the result
// register once the result side can take it. Throughput is one word per cycle while
// the output is not stalled, set by the combinational multiply and 48-bit saturating add
// that closes each angle's feedback loop. Calibration words (tuser = 0) accumulate
// absolute rates; every CAL_SAMPLES of them the dead-band thresholds are reloaded
// and calibration_done is flagged. Integration words (tuser = 1) apply the dead
// band and add rate * gain to the Q15.32 angles. Write the gain only while idle.
module gyro_deadband_angle_integrator_top #(
    parameter int CAL_SAMPLES = gdai_pkg::CAL_SAMPLES_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_wr_en,
    input  logic [23:0]  i_cfg_wr_data,    // rate_gain
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    input  logic [47:0]  i_s_axis_tdata,   // x_rate, y_rate, z_rate
    input  logic         i_s_axis_tuser,   // action
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    output logic [143:0] o_m_axis_tdata,   // x_angle_out, y_angle_out, z_angle_out
    output logic         o_m_axis_tuser    // calibration_done
);

    localparam int NA = gdai_pkg::NUM_AXES;
    localparam int RW = gdai_pkg::RATE_W;
    localparam int AW = gdai_pkg::ANGLE_W;

    gdai_pkg::t_gain     r_gain;
    logic                r_in_v;
    logic                r_in_act;
    gdai_pkg::t_rate     r_in_rate [NA];
    logic                r_out_v;
    gdai_pkg::t_angle    r_out_angle [NA];
    logic                r_out_done;
    logic                w_acc;
    logic                w_adv;
    gdai_pkg::t_step_ctl w_ctl;
    gdai_pkg::t_thr      w_thr [NA];
    gdai_pkg::t_angle    w_angle [NA];
    gdai_pkg::t_angle    w_angle_next [NA];
    logic                w_done;

    // handshake
    assign w_adv           = r_in_v && (!r_out_v || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_v || w_adv;
    assign w_acc           = i_s_axis_tvalid && o_s_axis_tready;
    assign w_ctl.cal_en    = w_adv && (r_in_act == gdai_pkg::ACT_CAL);
    assign w_ctl.int_en    = w_adv && (r_in_act == gdai_pkg::ACT_INT);

    // gain register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain <= gdai_pkg::GAIN_RESET;
        end else if (i_cfg_wr_en) begin
            r_gain <= i_cfg_wr_data;
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v <= 1'b0;
        end else if (w_acc) begin
            r_in_v <= 1'b1;
        end else if (w_adv) begin
            r_in_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_in_act <= i_s_axis_tuser;
            for (int i = 0; i < NA; i++) begin
                r_in_rate[i] <= i_s_axis_tdata[i*RW +: RW];
            end
        end
    end

    gdai_cal #(
        .CAL_SAMPLES (CAL_SAMPLES)
    ) u_cal (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl),
        .i_rate  (r_in_rate),
        .o_thr   (w_thr),
        .o_done  (w_done)
    );

    for (genvar g = 0; g < NA; g++) begin : g_axis
        gdai_axis u_axis (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctl        (w_ctl),
            .i_rate       (r_in_rate[g]),
            .i_thr        (w_thr[g]),
            .i_gain       (r_gain),
            .o_angle      (w_angle[g]),
            .o_angle_next (w_angle_next[g])
        );
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (w_adv) begin
            r_out_v <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out_done <= w_done;
            for (int i = 0; i < NA; i++) begin
                r_out_angle[i] <= w_angle_next[i];
            end
        end
    end

    assign o_m_axis_tvalid = r_out_v;
    assign o_m_axis_tuser  = r_out_done;
    always_comb begin
        for (int i = 0; i < NA; i++) begin
            o_m_axis_tdata[i*AW +: AW] = r_out_angle[i];
        end
    end

`ifndef SYNTHESIS
    // calibration can only finish on a calibration word
    a_done_cal_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctl.int_en |-> !w_done)
        else $error("calibration_done raised on an integration word");

    // a calibration word leaves every angle untouched
    a_cal_keeps_angle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctl.cal_en |=> ($stable(w_angle[0]) && $stable(w_angle[1])
                          && $stable(w_angle[2])))
        else $error("angle changed on a calibration word");

    // a held input word is not dropped while the result side stalls
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_v && !w_adv) |=> r_in_v)
        else $error("pending input word lost");

    // result register reflects the angle state after each word
    a_out_matches_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_adv |=> (r_out_angle[0] == w_angle[0] && r_out_angle[1] == w_angle[1]
                   && r_out_angle[2] == w_angle[2]))
        else $error("result word differs from angle state");
`endif

endmodule

### sv/gdai_cal.sv
// calibration unit: absolute-rate sums, sample count and dead-band thresholds
module gdai_cal #(
    parameter int CAL_SAMPLES = gdai_pkg::CAL_SAMPLES_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  gdai_pkg::t_step_ctl i_ctl,
    input  gdai_pkg::t_rate     i_rate [gdai_pkg::NUM_AXES],
    output gdai_pkg::t_thr      o_thr  [gdai_pkg::NUM_AXES],
    output logic                o_done
);

    localparam int NA   = gdai_pkg::NUM_AXES;
    localparam int SW   = gdai_pkg::SUM_W;
    localparam int CW   = gdai_pkg::CNT_W;
    localparam int RW   = gdai_pkg::RECIP_W;
    localparam int AW   = gdai_pkg::ABS_W;
    localparam int TW   = gdai_pkg::THR_W;
    localparam int PW   = SW + RW;
    // reciprocal of the run length, exact for any sum below 2^23
    localparam logic [RW-1:0] RECIP =
        RW'(((64'd1 << gdai_pkg::RECIP_SHIFT) + 64'(CAL_SAMPLES) - 64'd1) / 64'(CAL_SAMPLES));
    localparam logic [CW-1:0] CNT_END = CW'(CAL_SAMPLES);

    logic [SW-1:0]  r_sum [NA];
    logic [SW-1:0]  n_sum [NA];
    logic [CW-1:0]  r_cnt;
    logic [CW-1:0]  n_cnt;
    gdai_pkg::t_thr r_thr [NA];
    logic [AW-1:0]  w_abs [NA];
    logic [PW-1:0]  w_prod [NA];
    gdai_pkg::t_thr w_quot [NA];

    // saturated absolute value, running sums and quotient by reciprocal
    always_comb begin
        for (int i = 0; i < NA; i++) begin
            if (i_rate[i] == {1'b1, {(gdai_pkg::RATE_W-1){1'b0}}}) begin
                w_abs[i] = {AW{1'b1}};
            end else if (i_rate[i][gdai_pkg::RATE_W-1]) begin
                w_abs[i] = AW'(-i_rate[i]);
            end else begin
                w_abs[i] = AW'(i_rate[i]);
            end
            n_sum[i]  = r_sum[i] + SW'(w_abs[i]);
            w_prod[i] = PW'(n_sum[i]) * PW'(RECIP);
            w_quot[i] = w_prod[i][gdai_pkg::RECIP_SHIFT +: TW];
        end
        n_cnt  = r_cnt + CW'(1);
        o_done = i_ctl.cal_en && (n_cnt >= CNT_END);
    end

    // state update on each calibration word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            for (int i = 0; i < NA; i++) begin
                r_sum[i] <= '0;
                r_thr[i] <= '0;
            end
        end else if (i_ctl.cal_en) begin
            if (o_done) begin
                r_cnt <= '0;
                for (int i = 0; i < NA; i++) begin
                    r_sum[i] <= '0;
                    r_thr[i] <= w_quot[i];
                end
            end else begin
                r_cnt <= n_cnt;
                for (int i = 0; i < NA; i++) begin
                    r_sum[i] <= n_sum[i];
                end
            end
        end
    end

    assign o_thr = r_thr;

endmodule

### sv/gdai_axis.sv
// one axis: dead band, rate times gain and saturating angle accumulator
module gdai_axis (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  gdai_pkg::t_step_ctl i_ctl,
    input  gdai_pkg::t_rate     i_rate,
    input  gdai_pkg::t_thr      i_thr,
    input  gdai_pkg::t_gain     i_gain,
    output gdai_pkg::t_angle    o_angle,
    output gdai_pkg::t_angle    o_angle_next
);

    localparam int RW = gdai_pkg::RATE_W;
    localparam int PW = gdai_pkg::PROD_W;
    localparam int AW = gdai_pkg::ANGLE_W;

    gdai_pkg::t_angle    r_angle;
    gdai_pkg::t_angle    n_angle;
    logic [RW:0]         w_mag;
    gdai_pkg::t_rate     w_rate;
    logic signed [PW-1:0] w_prod;
    logic signed [AW:0]  w_sum;
    gdai_pkg::t_angle    w_sat;

    always_comb begin
        // magnitude, with the most negative rate kept at 32768
        w_mag  = i_rate[RW-1] ? (RW+1)'(-{i_rate[RW-1], i_rate})
                              : (RW+1)'({i_rate[RW-1], i_rate});
        w_rate = (w_mag < (RW+1)'(i_thr)) ? '0 : i_rate;
        // signed rate times unsigned gain
        w_prod = PW'(w_rate) * PW'($signed({1'b0, i_gain}));
        w_sum  = (AW+1)'(r_angle) + (AW+1)'(w_prod);
        // saturate on overflow, then clear at exactly plus or minus 360
        if (w_sum[AW] != w_sum[AW-1]) begin
            w_sat = w_sum[AW] ? gdai_pkg::ANGLE_MIN : gdai_pkg::ANGLE_MAX;
        end else begin
            w_sat = w_sum[AW-1:0];
        end
        if (w_sat == gdai_pkg::DEG360 || w_sat == -gdai_pkg::DEG360) begin
            n_angle = '0;
        end else begin
            n_angle = w_sat;
        end
        o_angle_next = i_ctl.int_en ? n_angle : r_angle;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_angle <= '0;
        end else if (i_ctl.int_en) begin
            r_angle <= n_angle;
        end
    end

    assign o_angle = r_angle;

endmodule
